@@ sv/adcss_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the segment decoder for the ADC to seven-segment scanner.
// No dependencies.
package adcss_pkg;

   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_TICK   = 1'b1;

   // reading*50000/1023 as (reading*SCALE_MUL) >> SCALE_SHIFT, exact for 10-bit readings
   localparam logic [25:0] SCALE_MUL   = 26'd51250049;
   localparam int unsigned SCALE_SHIFT = 20;
   localparam logic [13:0] SAT_LIMIT   = 14'd9999;

   // reciprocals for the digit split, exact for values up to 9999
   localparam logic [15:0] RECIP_10   = 16'd52429;  // >> 19
   localparam logic [12:0] RECIP_100  = 13'd5243;   // >> 19
   localparam logic [13:0] RECIP_1000 = 14'd8389;   // >> 23

   localparam logic [7:0] PATTERN_C = 8'h39;
   localparam logic [7:0] DP_MASK   = 8'h80;

   localparam logic [1:0] POS_LETTER   = 2'd0;
   localparam logic [1:0] POS_HUNDREDS = 2'd2;

   typedef logic [3:0][3:0] digits_type;

   typedef struct packed {
      logic       is_tick;
      digits_type digits;
   } mid_entry_type;

   typedef struct packed {
      logic [7:0] segments;
      logic [3:0] digit_select;
   } rsp_entry_type;

   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      unique case (digit)
         4'd0:    pat = 8'h3f;
         4'd1:    pat = 8'h06;
         4'd2:    pat = 8'h5b;
         4'd3:    pat = 8'h4f;
         4'd4:    pat = 8'h66;
         4'd5:    pat = 8'h6d;
         4'd6:    pat = 8'h7d;
         4'd7:    pat = 8'h07;
         4'd8:    pat = 8'h7f;
         4'd9:    pat = 8'h6f;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

endpackage

@@ sv/adcss_queue.sv @@
`timescale 1ns / 1ps
// Small first-in first-out queue with push/full and pop/empty sides.
// No dependencies.
module adcss_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

@@ sv/adcss_front.sv @@
`timescale 1ns / 1ps
// Front end: takes items, scales and saturates readings, splits them into decimal digits.
// Depends on adcss_pkg.
module adcss_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic                    req_action,
   input  logic [9:0]              req_sample,
   output logic                    mid_push,
   output adcss_pkg::mid_entry_type mid_entry,
   input  logic                    mid_full
);

   logic        advance;

   // stage 1: scaling product
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_tick_ff;
   logic [15:0] s1_scaled_ff;
   logic [35:0] scale_prod;

   // stage 2: saturated value and quotients
   logic        s2_valid_ff, s2_valid_in;
   logic        s2_tick_ff;
   logic [13:0] s2_value_ff;
   logic [9:0]  s2_q10_ff;
   logic [6:0]  s2_q100_ff;
   logic [3:0]  s2_q1000_ff;

   logic [13:0] sat_value;
   logic [29:0] prod10;
   logic [26:0] prod100;
   logic [27:0] prod1000;

   logic [13:0] ones_w;
   logic [9:0]  tens_w;
   logic [6:0]  hund_w;

   // whole pipeline moves together; it only halts when its last stage cannot drain
   assign advance = !s2_valid_ff || !mid_full;
   assign full    = !advance;

   assign scale_prod = 36'(req_sample) * 36'(adcss_pkg::SCALE_MUL);

   assign sat_value = (s1_scaled_ff > 16'(adcss_pkg::SAT_LIMIT)) ?
                      adcss_pkg::SAT_LIMIT : s1_scaled_ff[13:0];
   assign prod10    = 30'(sat_value) * 30'(adcss_pkg::RECIP_10);
   assign prod100   = 27'(sat_value) * 27'(adcss_pkg::RECIP_100);
   assign prod1000  = 28'(sat_value) * 28'(adcss_pkg::RECIP_1000);

   // remainders: x - 10*q, with the times ten as shift and add
   assign ones_w = s2_value_ff - ((14'(s2_q10_ff) << 3) + (14'(s2_q10_ff) << 1));
   assign tens_w = s2_q10_ff - ((10'(s2_q100_ff) << 3) + (10'(s2_q100_ff) << 1));
   assign hund_w = s2_q100_ff - ((7'(s2_q1000_ff) << 3) + (7'(s2_q1000_ff) << 1));

   assign mid_push            = s2_valid_ff && !mid_full;
   assign mid_entry.is_tick   = s2_tick_ff;
   assign mid_entry.digits[0] = ones_w[3:0];
   assign mid_entry.digits[1] = tens_w[3:0];
   assign mid_entry.digits[2] = hund_w[3:0];
   assign mid_entry.digits[3] = s2_q1000_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s2_valid_in = s2_valid_ff;
      if (advance) begin
         s1_valid_in = push;
         s2_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_tick_ff   <= (req_action == adcss_pkg::ACTION_TICK);
         s1_scaled_ff <= scale_prod[35:adcss_pkg::SCALE_SHIFT];
         s2_tick_ff   <= s1_tick_ff;
         s2_value_ff  <= sat_value;
         s2_q10_ff    <= prod10[28:19];
         s2_q100_ff   <= prod100[25:19];
         s2_q1000_ff  <= prod1000[26:23];
      end
   end

endmodule

@@ sv/adcss_back.sv @@
`timescale 1ns / 1ps
// Back end: holds the digit store and scan position, turns ticks into display words.
// Depends on adcss_pkg.
module adcss_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     mid_empty,
   input  adcss_pkg::mid_entry_type mid_entry,
   output logic                     mid_pop,
   input  logic                     rsp_full,
   output logic                     rsp_push,
   output adcss_pkg::rsp_entry_type rsp_entry
);

   adcss_pkg::digits_type digits_ff, digits_in;
   logic [1:0]            scan_ff, scan_in;
   logic [7:0]            seg;

   // a sample only touches the store, so it never waits on the result side
   assign mid_pop  = !mid_empty && (!mid_entry.is_tick || !rsp_full);
   assign rsp_push = mid_pop && mid_entry.is_tick;

   always_comb begin
      if (scan_ff == adcss_pkg::POS_LETTER) begin
         seg = adcss_pkg::PATTERN_C;
      end else begin
         seg = adcss_pkg::seg_pattern(digits_ff[scan_ff]);
         if (scan_ff == adcss_pkg::POS_HUNDREDS) begin
            seg = seg | adcss_pkg::DP_MASK;
         end
      end
   end

   assign rsp_entry.segments     = seg;
   assign rsp_entry.digit_select = 4'b0001 << scan_ff;

   always_comb begin
      digits_in = digits_ff;
      scan_in   = scan_ff;
      if (mid_pop) begin
         if (mid_entry.is_tick) begin
            scan_in = scan_ff + 1'b1;
         end else begin
            digits_in = mid_entry.digits;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff <= '0;
         scan_ff   <= '0;
      end else begin
         digits_ff <= digits_in;
         scan_ff   <= scan_in;
      end
   end

endmodule

@@ sv/adc_to_seven_segment_scanner.sv @@
`timescale 1ns / 1ps
// Multiplexed four-position seven-segment driver fed by 10-bit converter readings.
// A sample item (action 0) is scaled to reading*50000/1023, saturated at 9999 and split
// into decimal digits; it gives no result. A tick item (action 1) returns the segment
// byte and one-hot select for the current scan position, then steps the position.
// Position 0 shows a 'C', positions 1..3 the tens, hundreds (with decimal point) and
// thousands. One item is taken per cycle while full is low. An item passes the scaling
// and digit-split stages, then passes a short queue to the display store; a tick's result
// enters the result queue at the same edge that it leaves that queue. Depends on
// adcss_pkg, adcss_queue, adcss_front and adcss_back.
module adc_to_seven_segment_scanner #(
   parameter int unsigned MID_DEPTH = 2,
   parameter int unsigned RSP_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic       req_action,
   input  logic [9:0] req_sample,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_segments,
   output logic [3:0] rsp_digit_select
);

   logic                     mid_push, mid_full, mid_pop, mid_empty;
   adcss_pkg::mid_entry_type mid_wdata, mid_rdata;
   logic                     rsp_push, rsp_full;
   adcss_pkg::rsp_entry_type rsp_wdata, rsp_rdata;

   adcss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_action (req_action),
      .req_sample (req_sample),
      .mid_push   (mid_push),
      .mid_entry  (mid_wdata),
      .mid_full   (mid_full)
   );

   adcss_queue #(
      .WIDTH ($bits(adcss_pkg::mid_entry_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (mid_wdata),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   adcss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_entry (mid_rdata),
      .mid_pop   (mid_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_entry (rsp_wdata)
   );

   adcss_queue #(
      .WIDTH ($bits(adcss_pkg::rsp_entry_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_wdata),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_rdata),
      .empty (empty)
   );

   assign rsp_segments     = rsp_rdata.segments;
   assign rsp_digit_select = rsp_rdata.digit_select;

endmodule
